// File: design/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// Shared types and constants for the three-component vector normalizer.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int unsigned COMP_W = 32;
  localparam int unsigned SUM_W  = 64;
  localparam int unsigned QUO_W  = 61;
  localparam int unsigned UNIT_W = 32;

  typedef struct packed {
    logic signed [COMP_W-1:0] comp_x;
    logic signed [COMP_W-1:0] comp_y;
    logic signed [COMP_W-1:0] comp_z;
  } vec_in_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
    logic [COMP_W-1:0]        magnitude;
    logic                     is_zero;
  } vec_out_t;

  // state of one division step for all three components
  typedef struct packed {
    logic [SUM_W-1:0]            s;
    logic [2:0][SUM_W-1:0]       r;
    logic [2:0][QUO_W-1:0]       q;
  } div_t;

  // sideband carried alongside the arithmetic
  typedef struct packed {
    logic [2:0]        neg;
    logic              zero;
    logic [COMP_W-1:0] mag;
  } side_t;

endpackage

// File: design/vn_div_cell.sv
// ----------------------------------------------------------------------------
// vn_div_cell
// One restoring division step: a*a*2^60 / S, one quotient bit per lane.
// ----------------------------------------------------------------------------
module vn_div_cell import vn_pkg::*; #(
  parameter bit FIRST = 1'b0
) (
  input  logic clk,
  input  div_t d,
  output div_t q
);

  div_t nxt;

  always_comb begin
    logic [SUM_W:0] sh;
    logic [SUM_W:0] dif;
    logic           ge;
    nxt   = d;
    for (int i = 0; i < 3; i++) begin
      sh  = FIRST ? {1'b0, d.r[i]} : {d.r[i], 1'b0};
      dif = sh - {1'b0, d.s};
      ge  = (sh >= {1'b0, d.s});
      nxt.r[i] = ge ? dif[SUM_W-1:0] : sh[SUM_W-1:0];
      nxt.q[i] = {d.q[i][QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    q <= nxt;
  end

endmodule

// File: design/vn_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vn_sqrt_cell
// One digit of a restoring integer square root, two radicand bits per cell.
// ----------------------------------------------------------------------------
module vn_sqrt_cell #(
  parameter int unsigned W = 64
) (
  input  logic             clk,
  input  logic [W/2+1:0]   rem_in,
  input  logic [W/2-1:0]   root_in,
  input  logic [W-1:0]     val_in,
  output logic [W/2+1:0]   rem_out,
  output logic [W/2-1:0]   root_out,
  output logic [W-1:0]     val_out
);

  logic [W/2+3:0] rem2;
  logic [W/2+3:0] trial;
  logic [W/2+3:0] dif;
  logic           ge;

  assign rem2  = {rem_in, val_in[W-1:W-2]};
  assign trial = {2'b00, root_in, 2'b01};
  assign dif   = rem2 - trial;
  assign ge    = (rem2 >= trial);

  always_ff @(posedge clk) begin
    rem_out  <= ge ? dif[W/2+1:0] : rem2[W/2+1:0];
    root_out <= {root_in[W/2-2:0], ge};
    val_out  <= {val_in[W-3:0], 2'b00};
  end

endmodule

// File: design/vector3_normalize.sv
// ----------------------------------------------------------------------------
// vector3_normalize
// Magnitude and unit vector of a signed Q16.16 three-component vector.
// ----------------------------------------------------------------------------
// channel   direction  handshake         payload
// command   in         start / busy      vec    (vec_in_t)
// result    out        done (strobe)     result (vec_out_t)
//
// One transaction per cycle; busy is always low.
// Pipeline: abs, square and sum registers, 61 division cells, 31 root cells,
// one output register. The division chain sets the depth.
// Synchronous reset clears the valid line; payload registers are not reset.
// The receiver cannot stall; done is high for one cycle per result.
// ----------------------------------------------------------------------------
module vector3_normalize import vn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  vec_in_t  vec,
  output logic     done,
  output vec_out_t result
);

  localparam int unsigned ST_S    = 2;
  localparam int unsigned MAG_AT  = ST_S + 32;
  localparam int unsigned DIV_END = ST_S + QUO_W;
  localparam int unsigned SQ_END  = DIV_END + 31;

  logic [SQ_END:0]        vld;
  side_t                  side [SQ_END+1];
  logic [2:0][COMP_W-1:0] a;
  logic [2:0][COMP_W-1:0] a_r;
  logic [2:0][SUM_W-1:0]  a2;
  logic [2:0][SUM_W-1:0]  a2_d;
  logic [SUM_W-1:0]       s_r;
  logic [2:0]             neg;
  logic                   zero;

  assign busy = 1'b0;

  assign a[0] = vec.comp_x[COMP_W-1] ? ~vec.comp_x + 1'b1 : vec.comp_x;
  assign a[1] = vec.comp_y[COMP_W-1] ? ~vec.comp_y + 1'b1 : vec.comp_y;
  assign a[2] = vec.comp_z[COMP_W-1] ? ~vec.comp_z + 1'b1 : vec.comp_z;
  assign neg  = {vec.comp_z[COMP_W-1], vec.comp_y[COMP_W-1], vec.comp_x[COMP_W-1]};
  assign zero = (vec.comp_x == '0) && (vec.comp_y == '0) && (vec.comp_z == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[SQ_END-1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a;
    for (int i = 0; i < 3; i++) begin
      a2[i] <= a_r[i] * a_r[i];
    end
    a2_d <= a2;
    s_r  <= a2[0] + a2[1] + a2[2];
  end

  // magnitude chain
  logic [SUM_W/2+1:0] srem  [33];
  logic [SUM_W/2-1:0] sroot [33];
  logic [SUM_W-1:0]   sval  [33];

  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sval[0]  = s_r;

  for (genvar j = 0; j < 32; j++) begin : g_msq
    vn_sqrt_cell #(.W(SUM_W)) u_cell (
      .clk     (clk),
      .rem_in  (srem[j]),
      .root_in (sroot[j]),
      .val_in  (sval[j]),
      .rem_out (srem[j+1]),
      .root_out(sroot[j+1]),
      .val_out (sval[j+1])
    );
  end

  // division chain
  div_t dv [QUO_W+1];

  assign dv[0].s = s_r;
  assign dv[0].r = a2_d;
  assign dv[0].q = '0;

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    vn_div_cell #(.FIRST(k == 0)) u_cell (
      .clk(clk),
      .d  (dv[k]),
      .q  (dv[k+1])
    );
  end

  // unit root chains
  localparam int unsigned DW = QUO_W + 1;

  logic [DW/2+1:0] urem  [3][32];
  logic [DW/2-1:0] uroot [3][32];
  logic [DW-1:0]   uval  [3][32];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign urem[i][0]  = '0;
    assign uroot[i][0] = '0;
    assign uval[i][0]  = {1'b0, dv[QUO_W].q[i]};
    for (genvar j = 0; j < 31; j++) begin : g_usq
      vn_sqrt_cell #(.W(DW)) u_cell (
        .clk     (clk),
        .rem_in  (urem[i][j]),
        .root_in (uroot[i][j]),
        .val_in  (uval[i][j]),
        .rem_out (urem[i][j+1]),
        .root_out(uroot[i][j+1]),
        .val_out (uval[i][j+1])
      );
    end
  end

  // sideband line
  always_ff @(posedge clk) begin
    side[0] <= '{neg: neg, zero: zero, mag: '0};
    for (int k = 1; k <= SQ_END; k++) begin
      if (k == MAG_AT + 1) begin
        side[k] <= '{neg: side[k-1].neg, zero: side[k-1].zero, mag: sroot[32]};
      end else begin
        side[k] <= side[k-1];
      end
    end
  end

  // output register
  logic [2:0][UNIT_W-1:0] uo;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uo[i] = {1'b0, uroot[i][31]};
      if (side[SQ_END].neg[i]) begin
        uo[i] = ~uo[i] + 1'b1;
      end
      if (side[SQ_END].zero) begin
        uo[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[SQ_END];
    end
  end

  always_ff @(posedge clk) begin
    result.unit_x    <= uo[0];
    result.unit_y    <= uo[1];
    result.unit_z    <= uo[2];
    result.magnitude <= side[SQ_END].mag;
    result.is_zero   <= side[SQ_END].zero;
  end

  a_zero_mag: assert property (@(posedge clk) disable iff (rst)
    done && result.is_zero |-> result.magnitude == '0 && result.unit_x == '0)
    else $error("zero vector with nonzero outputs");

  a_mag_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && !result.is_zero |-> result.magnitude != '0)
    else $error("nonzero vector with zero magnitude");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.unit_x <= 32'sd1073741824 && result.unit_x >= -32'sd1073741824)
    else $error("unit_x out of range");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    vld[SQ_END] |=> done)
    else $error("result strobe lost");

endmodule

// File: tb/tb_vector3_normalize.sv
// ----------------------------------------------------------------------------
// tb_vector3_normalize
// Self-checking bench for the vector normalizer: a directed table, then
// bursty random vectors; every result is compared with a table value or a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_vector3_normalize;
  timeunit 1ns;
  timeprecision 1ps;
  import vn_pkg::*;

  localparam int LATENCY   = 96;
  localparam int WD_LIMIT  = 2000;
  localparam int N_RANDOM  = 1450;
  localparam logic [31:0] MIN_C = 32'h8000_0000;
  localparam logic [31:0] MAX_C = 32'h7fff_ffff;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  vec_in_t  vec = '0;
  logic     done;
  vec_out_t result;

  vec_out_t expected_q[$];
  int       errors = 0;
  int       idle_cycles = 0;

  vector3_normalize dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vec(vec), .done(done), .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] abs_comp(logic [31:0] c);
    if (c[31]) return 64'(-$signed({32'hffff_ffff, c}));
    return {32'd0, c};
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      logic [63:0] t;
      t = r | (64'd1 << b);
      if (128'(t) * 128'(t) <= 128'(v)) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] unit_comp(logic [31:0] c, logic [63:0] s);
    logic [63:0]  a, q;
    logic [127:0] rhs;
    a = abs_comp(c);
    rhs = (128'(a) * 128'(a)) << 60;
    q = 0;
    for (int b = 30; b >= 0; b--) begin
      logic [63:0] t;
      t = q | (64'd1 << b);
      if (128'(t) * 128'(t) * 128'(s) <= rhs) q = t;
    end
    if (c[31]) q = -q;
    return q[31:0];
  endfunction

  function automatic vec_out_t normalize(vec_in_t v);
    vec_out_t    o;
    logic [63:0] s;
    s = abs_comp(v.comp_x) * abs_comp(v.comp_x) + abs_comp(v.comp_y) * abs_comp(v.comp_y)
      + abs_comp(v.comp_z) * abs_comp(v.comp_z);
    o = '0;
    if (s == 0) begin
      o.is_zero = 1'b1;
      return o;
    end
    o.unit_x = unit_comp(v.comp_x, s);
    o.unit_y = unit_comp(v.comp_y, s);
    o.unit_z = unit_comp(v.comp_z, s);
    o.magnitude = 32'(isqrt64(s));
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", 32'd0, 32'd0);
      end else begin
        vec_out_t e;
        e = expected_q.pop_front();
        if (result.unit_x !== e.unit_x) report_mismatch("unit_x", result.unit_x, e.unit_x);
        if (result.unit_y !== e.unit_y) report_mismatch("unit_y", result.unit_y, e.unit_y);
        if (result.unit_z !== e.unit_z) report_mismatch("unit_z", result.unit_z, e.unit_z);
        if (result.magnitude !== e.magnitude)
          report_mismatch("magnitude", result.magnitude, e.magnitude);
        if (result.is_zero !== e.is_zero)
          report_mismatch("is_zero", 32'(result.is_zero), 32'(e.is_zero));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || done || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog expired");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // directed rows: vector, known result, whether the known result is used
  typedef struct {
    vec_in_t  v;
    vec_out_t r;
    bit       known;
  } row_t;
  row_t rows[$];

  function automatic vec_in_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vec_in_t v;
    v.comp_x = x; v.comp_y = y; v.comp_z = z;
    return v;
  endfunction

  function automatic vec_out_t mko(logic [31:0] ux, logic [31:0] uy, logic [31:0] uz,
                                   logic [31:0] m, logic zf);
    vec_out_t o;
    o.unit_x = ux; o.unit_y = uy; o.unit_z = uz; o.magnitude = m; o.is_zero = zf;
    return o;
  endfunction

  task automatic add_row(vec_in_t v, vec_out_t r, bit known);
    row_t w;
    w.v = v; w.r = r; w.known = known;
    rows.push_back(w);
  endtask

  // drive one transaction, waiting for acceptance
  task automatic send(vec_in_t v, vec_out_t e);
    start <= 1'b1;
    vec <= v;
    do @(posedge clk); while (busy);
    expected_q.push_back(e);
  endtask

  task automatic gap(int n);
    if (n > 0) begin
      start <= 1'b0;
      vec <= '0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return MIN_C;
      1: return MAX_C;
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      3: return 32'd0;
      4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    vec_in_t v;
    int burst;
    add_row(mk(0, 0, 0), mko(0, 0, 0, 0, 1), 1);
    add_row(mk(32'h0001_0000, 0, 0), mko(32'h4000_0000, 0, 0, 32'h0001_0000, 0), 1);
    add_row(mk(0, 32'hffff_0000, 0), mko(0, 32'hc000_0000, 0, 32'h0001_0000, 0), 1);
    add_row(mk(0, 0, MIN_C), mko(0, 0, 32'hc000_0000, 32'h8000_0000, 0), 1);
    add_row(mk(MAX_C, 0, 0), mko(32'h4000_0000, 0, 0, MAX_C, 0), 1);
    add_row(mk(0, 0, 1), mko(0, 0, 32'h4000_0000, 1, 0), 1);
    add_row(mk(32'hffff_ffff, 0, 0), mko(32'hc000_0000, 0, 0, 1, 0), 1);
    add_row(mk(MIN_C, MIN_C, MIN_C), '0, 0);
    add_row(mk(MAX_C, MAX_C, MAX_C), '0, 0);
    add_row(mk(MIN_C, MAX_C, MIN_C), '0, 0);
    add_row(mk(1, 1, 1), '0, 0);
    add_row(mk(32'hffff_ffff, 1, 32'hffff_ffff), '0, 0);
    add_row(mk(32'h0003_0000, 32'h0004_0000, 0), '0, 0);
    add_row(mk(1, MAX_C, 0), '0, 0);
    add_row(mk(32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff), '0, 0);
    add_row(mk(0, 0, 0), mko(0, 0, 0, 0, 1), 1);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send(rows[i].v, rows[i].known ? rows[i].r : normalize(rows[i].v));
      if (i % 4 == 3) gap($urandom_range(0, 3));
    end

    // drain fully once before random traffic
    gap(1);
    while (expected_q.size() != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
        v = mk(rand_comp(), rand_comp(), rand_comp());
        send(v, normalize(v));
      end
      if ($urandom_range(0, 3) != 0) gap($urandom_range(1, 12));
      if (n > N_RANDOM / 2 && n < N_RANDOM / 2 + 41) begin
        gap(1);
        while (expected_q.size() != 0) @(posedge clk);
      end
    end
    gap(1);

    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
